/* hw/rtl/pac_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pac_pkg
// Shared constants for the periodic autocorrelation check.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int unsigned CAND_W      = 28;
    localparam int unsigned BOUND_W     = 5;
    localparam int unsigned SEQ_LEN_DEF = 30;

    localparam logic [BOUND_W-1:0] BOUND_RST = 5'd2;

endpackage : pac_pkg
`default_nettype wire

/* hw/rtl/periodic_autocorrelation_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_autocorrelation_check
// Tests candidate sequences against a bound on their periodic sidelobes.
// ----------------------------------------------------------------------------
// The block takes one candidate request per clock cycle while o_in_stall is
// low and returns one result per request, in order. The three register stages
// are the input register, the per-shift mismatch counts and the result
// register; all shifts are evaluated in parallel, one counting lane per shift.
// Each stage moves on its own when the next one is free, so an idle slot is
// filled even while a result waits. The bound register is written with
// i_cfg_we and should only change while no request is in flight.
// ----------------------------------------------------------------------------
module periodic_autocorrelation_check
    import pac_pkg::*;
#(
    parameter int unsigned SEQ_LEN = SEQ_LEN_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_we,
    input  wire logic [BOUND_W-1:0] i_cfg_wdata,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [CAND_W-1:0]  i_candidate,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_passes,
    output logic      [CAND_W-1:0]  o_candidate_echo
);

    localparam int unsigned CNT_W = $clog2(SEQ_LEN);
    localparam int unsigned DIF_W = CNT_W + 2;
    localparam int unsigned MAG_W = (DIF_W > BOUND_W) ? DIF_W : BOUND_W;

    logic [BOUND_W-1:0] r_bound;

    logic               r_s1_valid;
    logic [CAND_W-1:0]  r_s1_cand;
    logic               r_s2_valid;
    logic [CAND_W-1:0]  r_s2_cand;
    logic [CNT_W-1:0]   r_s2_mis [1:SEQ_LEN-1];
    logic [CNT_W-1:0]   n_s2_mis [1:SEQ_LEN-1];
    logic               r_out_valid;
    logic               r_out_passes;
    logic [CAND_W-1:0]  r_out_cand;
    logic               n_out_passes;

    logic               out_ready;
    logic               s2_ready;
    logic               s1_ready;
    logic [SEQ_LEN-1:1] elem;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s2_ready   = !r_s2_valid || out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;

    assign o_out_valid      = r_out_valid;
    assign o_passes         = r_out_passes;
    assign o_candidate_echo = r_out_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= BOUND_RST;
        end else if (i_cfg_we) begin
            r_bound <= i_cfg_wdata;
        end
    end

    // Entry one is fixed at +1; entries past the candidate width read as -1.
    assign elem[1] = 1'b1;
    for (genvar k = 2; k < SEQ_LEN; k++) begin : g_elem
        if (k - 2 < CAND_W) begin : g_bit
            assign elem[k] = r_s1_cand[k-2];
        end else begin : g_low
            assign elem[k] = 1'b0;
        end
    end

    for (genvar t = 1; t < SEQ_LEN; t++) begin : g_lane
        pac_corr_lane #(
            .SEQ_LEN (SEQ_LEN),
            .SHIFT   (t),
            .CNT_W   (CNT_W)
        ) u_lane (
            .i_elem     (elem),
            .o_mismatch (n_s2_mis[t])
        );
    end

    // Each sum equals (SEQ_LEN - 2) minus twice the mismatch count.
    always_comb begin
        logic signed [DIF_W-1:0] dif;
        logic        [DIF_W-1:0] mag;
        n_out_passes = 1'b1;
        for (int t = 1; t < SEQ_LEN; t++) begin
            dif = $signed(DIF_W'(SEQ_LEN - 2)) - $signed({1'b0, r_s2_mis[t], 1'b0});
            mag = dif[DIF_W-1] ? DIF_W'(-dif) : DIF_W'(dif);
            if (MAG_W'(mag) > MAG_W'(r_bound)) begin
                n_out_passes = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_cand <= i_candidate;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_cand <= r_s1_cand;
            r_s2_mis  <= n_s2_mis;
        end
        if (out_ready && r_s2_valid) begin
            r_out_cand   <= r_s2_cand;
            r_out_passes <= n_out_passes;
        end
    end

endmodule : periodic_autocorrelation_check
`default_nettype wire

/* hw/rtl/pac_corr_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pac_corr_lane
// Counts the sign mismatches between the sequence and its copy rotated
// right by one fixed shift, over all pairs where neither entry is zero.
// ----------------------------------------------------------------------------
module pac_corr_lane #(
    parameter int unsigned SEQ_LEN = 30,
    parameter int unsigned SHIFT   = 1,
    parameter int unsigned CNT_W   = $clog2(SEQ_LEN)
) (
    input  wire logic [SEQ_LEN-1:1] i_elem,
    output logic      [CNT_W-1:0]   o_mismatch
);

    always_comb begin
        o_mismatch = '0;
        for (int j = 1; j < SEQ_LEN; j++) begin
            if (j != SHIFT) begin
                o_mismatch = o_mismatch
                    + CNT_W'(i_elem[j] ^ i_elem[(j + SEQ_LEN - SHIFT) % SEQ_LEN]);
            end
        end
    end

endmodule : pac_corr_lane
`default_nettype wire

/* dv/tb_periodic_autocorrelation_check.sv */
// ----------------------------------------------------------------------------
// tb_periodic_autocorrelation_check
// Self-checking bench for the periodic autocorrelation sidelobe check.
// ----------------------------------------------------------------------------
// Candidate requests wait in a queue and a clocked driver offers them with
// random idle bursts. For each accepted request, a predictor builds the
// +1/-1 sequence and rotates it against itself. A clocked monitor stalls the
// output at random and compares each result with the oldest predicted
// verdict. The run starts with directed candidates at the reset bound. It
// then steps through several bound settings, the extremes among them, with
// random candidates. Along the way the receiver holds off long enough to
// fill the pipeline.
// ----------------------------------------------------------------------------
module tb_periodic_autocorrelation_check;
    import pac_pkg::*;

    localparam int unsigned SEQ_N = SEQ_LEN_DEF;

    typedef struct packed {
        logic              passes;
        logic [CAND_W-1:0] cand;
    } t_verdict;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [BOUND_W-1:0] i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [CAND_W-1:0]  i_candidate;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_passes;
    logic [CAND_W-1:0]  o_candidate_echo;

    logic [CAND_W-1:0]  pending_cands[$];
    t_verdict           awaited_verdicts[$];
    t_verdict           head_verdict;
    logic [BOUND_W-1:0] bound_model;
    int                 n_accepted;
    int                 n_errors;
    int                 send_gap;
    int                 recv_gap;
    bit                 calm;
    bit                 hold_off;

    periodic_autocorrelation_check u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_candidate      (i_candidate),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_passes         (o_passes),
        .o_candidate_echo (o_candidate_echo)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    function automatic logic sidelobes_within(input logic [CAND_W-1:0] cand,
                                              input logic [BOUND_W-1:0] lim);
        int seq_val[SEQ_N];
        int acc;
        int src;
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < SEQ_N; k++) begin
            if (k == 0) begin
                seq_val[k] = 0;
            end else if (k == 1) begin
                seq_val[k] = 1;
            end else if (k - 2 < CAND_W && cand[k-2]) begin
                seq_val[k] = 1;
            end else begin
                seq_val[k] = -1;
            end
        end
        for (int t = 1; t < SEQ_N; t++) begin
            acc = 0;
            for (int j = 0; j < SEQ_N; j++) begin
                src = j - t;
                if (src < 0) begin
                    src += SEQ_N;
                end
                acc += seq_val[j] * seq_val[src];
            end
            if (acc < 0) begin
                acc = -acc;
            end
            if (acc > int'(lim)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [CAND_W-1:0] draw_candidate();
        logic [CAND_W-1:0] c;
        c = '0;
        case ($urandom_range(0, 5))
            0: begin
                repeat ($urandom_range(1, 4)) c[$urandom_range(0, CAND_W-1)] = 1'b1;
            end
            1: begin
                c = '1;
                repeat ($urandom_range(1, 4)) c[$urandom_range(0, CAND_W-1)] = 1'b0;
            end
            default: begin
                c = CAND_W'($urandom());
            end
        endcase
        return c;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        n_errors++;
    endtask

    task automatic wait_idle();
        while (pending_cands.size() != 0 || i_in_valid || awaited_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_bound(input logic [BOUND_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        bound_model = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [BOUND_W-1:0] value, input int count);
        write_bound(value);
        repeat (count) pending_cands.push_back(draw_candidate());
    endtask

    // Driver: holds a stalled request, otherwise idles or offers the next one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                awaited_verdicts.push_back(t_verdict'{
                    passes: sidelobes_within(i_candidate, bound_model),
                    cand:   i_candidate});
                n_accepted <= n_accepted + 1;
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_cands.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
                send_gap   <= $urandom_range(0, 11);
                i_in_valid <= 1'b0;
            end else if (pending_cands.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_candidate <= pending_cands.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks accepted results and chooses the next stall value.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_verdicts.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result for %07h", o_candidate_echo));
                end else begin
                    head_verdict = awaited_verdicts.pop_front();
                    if (o_passes !== head_verdict.passes) begin
                        flag_mismatch($sformatf("passes %b, expected %b for %07h",
                                                o_passes, head_verdict.passes,
                                                head_verdict.cand));
                    end
                    if (o_candidate_echo !== head_verdict.cand) begin
                        flag_mismatch($sformatf("echo %07h, expected %07h",
                                                o_candidate_echo, head_verdict.cand));
                    end
                end
            end
            if (hold_off) begin
                i_out_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                i_out_stall <= 1'b1;
                recv_gap    <= recv_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                recv_gap    <= $urandom_range(0, 11);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (n_accepted >= 150);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [CAND_W-1:0] directed[$];
        directed = '{28'h0000000, 28'hFFFFFFF, 28'h5555555, 28'hAAAAAAA,
                     28'h3333333, 28'hCCCCCCC, 28'h0F0F0F0, 28'hF0F0F0F,
                     28'h0000001, 28'h8000000, 28'h0002000, 28'hFFFFFFE,
                     28'h7FFFFFF, 28'hFFFDFFF, 28'h8000001, 28'h7FFFFFE,
                     28'h00FF00F, 28'h1234567, 28'hEDCBA98, 28'h0003FFF};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_candidate = '0;
        i_out_stall = 1'b0;
        bound_model = BOUND_RST;
        n_accepted  = 0;
        n_errors    = 0;
        send_gap    = 0;
        recv_gap    = 0;
        calm        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[i]) pending_cands.push_back(directed[i]);
        run_phase(5'd28, 80);
        run_phase(5'd0, 60);
        run_phase(5'd31, 60);
        run_phase(5'd12, 80);
        run_phase(5'd16, 60);
        run_phase(5'd8, 60);
        run_phase(5'd10, 80);
        run_phase(5'd14, 60);
        wait_idle();
        calm = 1'b1;
        run_phase(5'd2, 60);
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule : tb_periodic_autocorrelation_check
